### hdl/vupk_pkg.sv
`default_nettype none

package vupk_pkg;

    localparam int LANES   = 4;
    localparam int LANE_W  = 32;

    localparam logic [1:0] SZ_32  = 2'd0;
    localparam logic [1:0] SZ_16  = 2'd1;
    localparam logic [1:0] SZ_8   = 2'd2;
    localparam logic [1:0] SZ_RSV = 2'd3;

    localparam logic [1:0] GRP_S  = 2'd0;
    localparam logic [1:0] GRP_V2 = 2'd1;
    localparam logic [1:0] GRP_V3 = 2'd2;
    localparam logic [1:0] GRP_V4 = 2'd3;

    localparam logic [3:0] FMT_V4_5 = 4'd15;

    typedef logic [LANES-1:0][LANE_W-1:0] t_lanes;

    typedef struct packed {
        logic [3:0]  format;
        logic [3:0]  iteration;
        logic [1:0]  qw_position;
        logic        zero_extend;
        logic [63:0] src_low;
        logic [63:0] src_high;
    } t_in;

    typedef struct packed {
        logic [31:0] lane_x;
        logic [31:0] lane_y;
        logic [31:0] lane_z;
        logic [31:0] lane_w;
        logic        write_valid;
    } t_out;

endpackage

`default_nettype wire

### hdl/vector_unpack_format_expander.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in_data  (t_in)
// result    out        o_out_valid / i_out_ready   o_out_data (t_out)
//
// Each transaction is held in the input register and then moves to the
// result register, where o_out_valid rises; one transaction can be accepted
// in every cycle while the result side does not stall.
// The input register moves on whenever the result register is empty or being
// emptied, so a stall on the result side holds both stages once both are full.
// Reset clears both valid flags; the work vector is not reset.

module vector_unpack_format_expander
    import vupk_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic r_in_valid;
    logic n_in_valid;
    t_in  r_in;
    logic r_out_valid;
    logic n_out_valid;
    t_out r_out;
    t_out w_res;
    logic w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    vupk_core u_core (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_item (r_in),
        .o_res  (w_res)
    );

    always_comb begin
        n_in_valid  = i_in_valid ? 1'b1 : (r_in_valid && !w_adv);
        if (!o_in_ready) begin
            n_in_valid = r_in_valid;
        end
        n_out_valid = w_adv ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted transaction not held in the input register");

    a_adv_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced transaction missing from the result register");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed during a result stall");

    a_reserved_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.write_valid) |->
        (r_out.lane_x == '0 && r_out.lane_y == '0 && r_out.lane_z == '0 &&
         r_out.lane_w == '0))
        else $error("reserved format produced nonzero lanes");

endmodule

`default_nettype wire

### hdl/vupk_gather.sv
`default_nettype none

module vupk_gather
    import vupk_pkg::*;
(
    input  wire logic [1:0]   i_size,
    input  wire logic         i_zero_extend,
    input  wire logic [63:0]  i_src_low,
    input  wire logic [63:0]  i_src_high,
    output logic      [LANES-1:0][LANE_W-1:0] o_elem
);

    logic [127:0] w_src;

    assign w_src = {i_src_high, i_src_low};

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            case (i_size)
                SZ_32: begin
                    o_elem[k] = w_src[k*32 +: 32];
                end
                SZ_16: begin
                    o_elem[k] = {{16{~i_zero_extend & i_src_low[k*16 + 15]}},
                                 i_src_low[k*16 +: 16]};
                end
                SZ_8: begin
                    o_elem[k] = {{24{~i_zero_extend & i_src_low[k*8 + 7]}},
                                 i_src_low[k*8 +: 8]};
                end
                default: begin
                    o_elem[k] = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/vupk_core.sv
`default_nettype none

module vupk_core
    import vupk_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_in  i_item,
    output t_out      o_res
);

    // The work vector has no reset: it is defined by its first load.
    t_lanes     r_work;
    t_lanes     w_elem;
    t_lanes     w_lane;
    logic [1:0] w_group;
    logic [1:0] w_size;
    logic       w_first;
    logic       w_load;
    logic       w_valid;
    logic [1:0] w_res;
    logic [31:0] w_bcast;

    assign w_group = i_item.format[3:2];
    assign w_size  = i_item.format[1:0];
    assign w_first = (i_item.iteration == 4'd0);
    assign w_load  = (w_size != SZ_RSV) && (w_group == GRP_S || w_group == GRP_V2) && w_first;
    assign w_res   = i_item.iteration[3:2] + 2'd1 - i_item.qw_position;
    assign w_bcast = w_first ? w_elem[0] : r_work[i_item.iteration[1:0]];

    vupk_gather u_gather (
        .i_size        (w_size),
        .i_zero_extend (i_item.zero_extend),
        .i_src_low     (i_item.src_low),
        .i_src_high    (i_item.src_high),
        .o_elem        (w_elem)
    );

    always_comb begin
        w_lane  = '0;
        w_valid = 1'b1;
        if (i_item.format == FMT_V4_5) begin
            w_lane[0] = {24'd0, i_item.src_low[4:0], 3'd0};
            w_lane[1] = {24'd0, i_item.src_low[9:5], 3'd0};
            w_lane[2] = {24'd0, i_item.src_low[14:10], 3'd0};
            w_lane[3] = {24'd0, i_item.src_low[15], 7'd0};
        end else if (w_size == SZ_RSV) begin
            w_valid = 1'b0;
        end else begin
            case (w_group)
                GRP_S: begin
                    for (int k = 0; k < LANES; k++) begin
                        w_lane[k] = w_bcast;
                    end
                end
                GRP_V2: begin
                    if (w_first) begin
                        w_lane = {w_elem[1], w_elem[0], w_elem[1], w_elem[0]};
                    end else begin
                        w_lane = {r_work[3], r_work[2], r_work[3], r_work[2]};
                    end
                    if (w_size == SZ_32 && i_item.qw_position != 2'd0) begin
                        w_lane[3] = '0;
                    end
                end
                GRP_V3: begin
                    w_lane = w_elem;
                    if (w_size == SZ_16) begin
                        if (!i_item.iteration[0] && w_res == 2'd0) begin
                            w_lane[3] = '0;
                        end
                    end else if (i_item.iteration != {2'd0, i_item.qw_position}) begin
                        w_lane[3] = '0;
                    end
                end
                default: begin
                    w_lane = w_elem;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_load) begin
            r_work <= w_elem;
        end
    end

    assign o_res.lane_x      = w_lane[0];
    assign o_res.lane_y      = w_lane[1];
    assign o_res.lane_z      = w_lane[2];
    assign o_res.lane_w      = w_lane[3];
    assign o_res.write_valid = w_valid;

endmodule

`default_nettype wire
